// ===== rtl/core/bpim_pkg.sv =====
// Shared types and codes for the block partition index map.
`default_nettype none

package bpim_pkg;

	// Operation codes carried by the kind field.
	localparam logic [1:0] KIND_WRITE   = 2'd0;
	localparam logic [1:0] KIND_REBUILD = 2'd1;
	localparam logic [1:0] KIND_LOCATE  = 2'd2;
	localparam logic [1:0] KIND_GLOBAL  = 2'd3;

	// Result status codes.
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_RANGE   = 2'd1;
	localparam logic [1:0] STAT_UNBUILT = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_MY_PART   = 2'd0;
	localparam logic [1:0] CFG_NUM_PARTS = 2'd1;
	localparam logic [1:0] CFG_TOTAL     = 2'd2;

	// Offset table read address selects.
	localparam logic [1:0] RD_N   = 2'd0;
	localparam logic [1:0] RD_MY  = 2'd1;
	localparam logic [1:0] RD_MY1 = 2'd2;
	localparam logic [1:0] RD_MID = 2'd3;

	localparam logic [30:0] SAT31 = 31'h7FFF_FFFF;

	typedef struct packed {
		logic       accept;
		logic       rb_init;
		logic       rb_step;
		logic [1:0] rd_sel;
		logic       cap_lim;
		logic       cap_lo;
		logic       cap_hi;
		logic       srch_cmp;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		logic built;
		logic rb_last;
		logic range_err;
		logic srch_done;
	} sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/bpim_ctrl.sv =====
// Controller state machine for the block partition index map.
`default_nettype none

module bpim_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [1:0]      kind,
	input  wire bpim_pkg::sts_t  sts,
	output bpim_pkg::cmd_t       cmd,
	output logic                 busy
);
	import bpim_pkg::*;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_RB0      = 4'd1;
	localparam logic [3:0] S_RB       = 4'd2;
	localparam logic [3:0] S_RD_N     = 4'd3;
	localparam logic [3:0] S_RD_MY    = 4'd4;
	localparam logic [3:0] S_RD_MY1   = 4'd5;
	localparam logic [3:0] S_CAP_HI   = 4'd6;
	localparam logic [3:0] S_SRCH_RD  = 4'd7;
	localparam logic [3:0] S_SRCH_CMP = 4'd8;
	localparam logic [3:0] S_FIN      = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic [1:0] kind_q;

	always_comb begin
		cmd = '0;
		cmd.rd_sel = RD_N;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					if (kind == KIND_WRITE) begin
						state_d = S_FIN;
					end else if (kind == KIND_REBUILD) begin
						state_d = S_RB0;
					end else if ((kind inside {KIND_LOCATE, KIND_GLOBAL}) && sts.built) begin
						state_d = (kind == KIND_LOCATE) ? S_RD_N : S_RD_MY;
					end else begin
						state_d = S_FIN;
					end
				end
			end
			S_RB0: begin
				cmd.rb_init = 1'b1;
				state_d = S_RB;
			end
			S_RB: begin
				cmd.rb_step = 1'b1;
				if (sts.rb_last) begin
					state_d = S_FIN;
				end
			end
			S_RD_N: begin
				cmd.rd_sel = RD_N;
				state_d = S_RD_MY;
			end
			S_RD_MY: begin
				cmd.rd_sel = RD_MY;
				cmd.cap_lim = 1'b1;
				state_d = S_RD_MY1;
			end
			S_RD_MY1: begin
				cmd.rd_sel = RD_MY1;
				cmd.cap_lo = 1'b1;
				state_d = S_CAP_HI;
			end
			S_CAP_HI: begin
				cmd.cap_hi = 1'b1;
				if (kind_q == KIND_LOCATE && !sts.range_err) begin
					state_d = S_SRCH_RD;
				end else begin
					state_d = S_FIN;
				end
			end
			S_SRCH_RD: begin
				if (sts.srch_done) begin
					state_d = S_FIN;
				end else begin
					cmd.rd_sel = RD_MID;
					state_d = S_SRCH_CMP;
				end
			end
			S_SRCH_CMP: begin
				cmd.srch_cmp = 1'b1;
				state_d = S_SRCH_RD;
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q <= KIND_WRITE;
		end else begin
			state_q <= state_d;
			if (cmd.accept) begin
				kind_q <= kind;
			end
		end
	end

	assign busy = (state_q != S_IDLE);

	// Every item leaves through the finish state.
	a_idle_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(state_q) == S_FIN)
		else $error("controller went idle without a finish step");

endmodule

`default_nettype wire

// ===== rtl/core/bpim_dp.sv =====
// Datapath of the block partition index map: registers, tables, search and result logic.
`default_nettype none

module bpim_dp #(
	parameter int MAX_PARTS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire bpim_pkg::cmd_t      cmd,
	output bpim_pkg::sts_t           sts,
	input  wire logic [1:0]          kind,
	input  wire logic [3:0]          part_index,
	input  wire logic [30:0]         item_count,
	input  wire logic signed [31:0]  query_index,
	input  wire logic                cfg_wr,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [30:0]         cfg_data,
	output logic                     done,
	output logic [1:0]               status,
	output logic [3:0]               owner,
	output logic [30:0]              offset_in_owner,
	output logic                     is_mine,
	output logic [30:0]              global_index
);
	import bpim_pkg::*;

	localparam int CNT_AW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
	localparam int OFF_AW = $clog2(MAX_PARTS + 1);
	localparam int OFF_DEPTH = MAX_PARTS + 1;

	// Configuration registers.
	logic [3:0]  cfg_my_q;
	logic [4:0]  cfg_parts_q;
	logic [30:0] cfg_total_q;

	// Latched item.
	logic [1:0]  kind_q;
	logic [31:0] q_q;
	logic        part_err_q;

	// Count table with per-entry valid bits.
	logic [30:0]         cnt_mem [MAX_PARTS];
	logic [MAX_PARTS-1:0] cnt_vld_q;
	logic [30:0]         cnt_rd_q;
	logic                cnt_rd_vld_q;
	logic [CNT_AW-1:0]   cnt_rd_addr;
	logic [CNT_AW-1:0]   cnt_wr_addr;
	logic                cnt_we;

	// Offset table.
	logic [30:0]       off_mem [OFF_DEPTH];
	logic [30:0]       off_rd_q;
	logic [OFF_AW-1:0] off_rd_addr;
	logic [OFF_AW-1:0] off_wr_addr;
	logic [30:0]       off_wr_data;
	logic              off_we;

	// Rebuild walk.
	logic [CNT_AW-1:0] k_q;
	logic [30:0]       acc_q;
	logic              built_q;
	logic [30:0]       cnt_val;
	logic [31:0]       rb_sum;
	logic [30:0]       rb_sat;
	logic [30:0]       rb_next;
	logic              rb_last;

	// Lookup registers.
	logic [30:0]       lim_q;
	logic [30:0]       own_lo_q;
	logic [30:0]       own_hi_q;
	logic [OFF_AW-1:0] lo_q;
	logic [OFF_AW-1:0] hi_q;
	logic [30:0]       lo_val_q;

	logic [OFF_AW-1:0] n_eff;
	logic              own_used;
	logic [OFF_AW-1:0] my_addr;
	logic [OFF_AW-1:0] my1_addr;
	logic [OFF_AW:0]   mid_sum;
	logic [OFF_AW-1:0] mid;
	logic              q_neg;
	logic [30:0]       q_low;
	logic [31:0]       glob_sum;
	logic              glob_fit;
	logic              range_err;
	logic              mine;

	logic [1:0]  res_status;
	logic [3:0]  res_owner;
	logic [30:0] res_off;
	logic        res_mine;
	logic [30:0] res_glob;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_my_q <= '0;
			cfg_parts_q <= 5'd1;
			cfg_total_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_index)
				CFG_MY_PART:   cfg_my_q <= cfg_data[3:0];
				CFG_NUM_PARTS: cfg_parts_q <= cfg_data[4:0];
				CFG_TOTAL:     cfg_total_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Partitions in use, clamped to between one and the table size.
	always_comb begin
		if (cfg_parts_q == '0) begin
			n_eff = OFF_AW'(1);
		end else if (32'(cfg_parts_q) > MAX_PARTS) begin
			n_eff = OFF_AW'(MAX_PARTS);
		end else begin
			n_eff = OFF_AW'(cfg_parts_q);
		end
	end

	assign own_used = (32'(cfg_my_q) < 32'(n_eff));
	assign my_addr  = own_used ? OFF_AW'(cfg_my_q) : '0;
	assign my1_addr = own_used ? OFF_AW'(cfg_my_q) + 1'b1 : '0;
	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q} + 1'b1;
	assign mid      = mid_sum[OFF_AW:1];

	always_comb begin
		case (cmd.rd_sel)
			RD_N:    off_rd_addr = n_eff;
			RD_MY:   off_rd_addr = my_addr;
			RD_MY1:  off_rd_addr = my1_addr;
			RD_MID:  off_rd_addr = mid;
			default: off_rd_addr = n_eff;
		endcase
	end

	// Rebuild arithmetic.
	assign rb_last     = (k_q == CNT_AW'(MAX_PARTS - 1));
	assign cnt_val     = cnt_rd_vld_q ? cnt_rd_q : '0;
	assign rb_sum      = {1'b0, acc_q} + {1'b0, cnt_val};
	assign rb_sat      = rb_sum[31] ? SAT31 : rb_sum[30:0];
	assign rb_next     = (32'(k_q) < 32'(n_eff)) ? rb_sat : acc_q;
	assign cnt_rd_addr = (cmd.rb_init || rb_last) ? '0 : k_q + 1'b1;
	assign cnt_we      = cmd.accept && (kind == KIND_WRITE) && (32'(part_index) < MAX_PARTS);
	assign cnt_wr_addr = CNT_AW'(part_index);
	assign off_we      = cmd.rb_init || cmd.rb_step;
	assign off_wr_addr = cmd.rb_init ? '0 : OFF_AW'(k_q) + 1'b1;
	assign off_wr_data = cmd.rb_init ? '0 : rb_next;

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_wr_addr] <= item_count;
		end
		cnt_rd_q <= cnt_mem[cnt_rd_addr];
		cnt_rd_vld_q <= cnt_vld_q[cnt_rd_addr];
	end

	always_ff @(posedge clk) begin
		if (off_we) begin
			off_mem[off_wr_addr] <= off_wr_data;
		end
		off_rd_q <= off_mem[off_rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q <= '0;
			built_q <= 1'b0;
		end else begin
			if (cnt_we) begin
				cnt_vld_q[cnt_wr_addr] <= 1'b1;
			end
			if (cmd.rb_step && rb_last) begin
				built_q <= 1'b1;
			end
		end
	end

	// Query checks.
	assign q_neg    = q_q[31];
	assign q_low    = q_q[30:0];
	assign glob_sum = {1'b0, own_lo_q} + {1'b0, q_low};
	assign glob_fit = (glob_sum < {1'b0, own_hi_q});
	assign range_err = (kind_q == KIND_GLOBAL) ? (q_neg || !own_used || !glob_fit)
		: (q_neg || (q_low >= lim_q));
	assign mine = !q_neg && own_used && (q_low >= own_lo_q) && (q_low < own_hi_q);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q <= kind;
			q_q <= query_index;
			part_err_q <= !(32'(part_index) < MAX_PARTS);
		end
		if (cmd.rb_init) begin
			k_q <= '0;
			acc_q <= '0;
		end else if (cmd.rb_step) begin
			k_q <= k_q + 1'b1;
			acc_q <= rb_next;
		end
		if (cmd.cap_lim) begin
			lim_q <= (cfg_total_q != '0) ? cfg_total_q : off_rd_q;
		end
		if (cmd.cap_lo) begin
			own_lo_q <= off_rd_q;
		end
		if (cmd.cap_hi) begin
			own_hi_q <= off_rd_q;
			lo_q <= '0;
			hi_q <= n_eff - 1'b1;
			lo_val_q <= '0;
		end else if (cmd.srch_cmp) begin
			if (off_rd_q <= q_low) begin
				lo_q <= mid;
				lo_val_q <= off_rd_q;
			end else begin
				hi_q <= mid - 1'b1;
			end
		end
	end

	assign sts.built     = built_q;
	assign sts.rb_last   = rb_last;
	assign sts.range_err = range_err;
	assign sts.srch_done = (lo_q == hi_q);

	always_comb begin
		res_status = STAT_OK;
		res_owner = '0;
		res_off = '0;
		res_mine = 1'b0;
		res_glob = '0;
		case (kind_q)
			KIND_WRITE: begin
				res_status = part_err_q ? STAT_RANGE : STAT_OK;
			end
			KIND_REBUILD: begin
				res_status = STAT_OK;
			end
			KIND_LOCATE: begin
				if (!built_q) begin
					res_status = STAT_UNBUILT;
				end else begin
					res_mine = mine;
					if (range_err) begin
						res_status = STAT_RANGE;
					end else begin
						res_owner = 4'(lo_q);
						res_off = q_low - lo_val_q;
					end
				end
			end
			default: begin
				if (!built_q) begin
					res_status = STAT_UNBUILT;
				end else if (range_err) begin
					res_status = STAT_RANGE;
				end else begin
					res_glob = glob_sum[30:0];
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status <= res_status;
			owner <= res_owner;
			offset_in_owner <= res_off;
			is_mine <= res_mine;
			global_index <= res_glob;
		end
	end

	a_search_open: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.srch_cmp |-> lo_q < hi_q)
		else $error("search step issued on a closed interval");

	a_owner_sound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && kind_q == KIND_LOCATE && built_q && !range_err)
		|-> (lo_val_q <= q_low) && (32'(lo_q) < 32'(n_eff)))
		else $error("owner start above the index or owner beyond partitions in use");

	a_rebuild_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rb_step && !rb_last) |=> cmd.rb_step && (k_q == $past(k_q) + 1'b1))
		else $error("rebuild walk broke off early");

endmodule

`default_nettype wire

// ===== rtl/core/block_partition_index_map_core.sv =====
// Top level of the block partition index map: controller, datapath and configuration port.
`default_nettype none

// Block-distribution owner lookup over up to MAX_PARTS partitions. Each item is taken
// at a clock edge where start is high and busy is low; busy then stays high until the
// item's single result has been formed, and the result appears on the result ports for
// exactly one cycle with done high. The receiver cannot hold a result off, so it must
// take the transfer in that cycle. A new item may be started in the same cycle that
// done is high. A count write, and a locate or globalize on a map that was never rebuilt,
// go straight from acceptance to the finish step. A globalize reads the offset table at
// its own partition and the one after it before finishing; a locate also reads the entry
// at the partition count first and, unless the index is out of range, then runs a binary
// search over the offset table, each probe a read followed by a compare. The search needs
// at most ceil(log2(n)) probes for n partitions in use; the table has a single registered
// read port. A rebuild walks the count table one entry per cycle, saturating the running
// prefix sum at 2^31-1. No clearing pass follows reset: count entries carry valid bits,
// and the offset table is only consulted once a rebuild has filled it. Configuration
// writes (my_partition, num_parts, total_items at indexes 0, 1, 2) are always accepted,
// cfg_ready being tied high; a write to index 3 is dropped. Registers should only be
// changed while no item is in flight.
module block_partition_index_map_core #(
	parameter int MAX_PARTS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         kind,
	input  wire logic [3:0]         part_index,
	input  wire logic [30:0]        item_count,
	input  wire logic signed [31:0] query_index,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [30:0]        cfg_data,
	output logic                    done,
	output logic [1:0]              status,
	output logic [3:0]              owner,
	output logic [30:0]             offset_in_owner,
	output logic                    is_mine,
	output logic [30:0]             global_index
);
	import bpim_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic cfg_wr;

	// The register file never stalls a configuration transfer.
	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && cfg_ready;

	// The controller sequences reads of the offset table, the rebuild walk and the
	// search probes; it sees the datapath only through the status bundle.
	bpim_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// The datapath holds the tables, the configuration registers and the result register.
	bpim_dp #(
		.MAX_PARTS (MAX_PARTS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.kind            (kind),
		.part_index      (part_index),
		.item_count      (item_count),
		.query_index     (query_index),
		.cfg_wr          (cfg_wr),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.done            (done),
		.status          (status),
		.owner           (owner),
		.offset_in_owner (offset_in_owner),
		.is_mine         (is_mine),
		.global_index    (global_index)
	);

endmodule

`default_nettype wire
